// ===== rtl/core/nace_pkg.sv =====
// Shared constants, codes and types of the normalized autocorrelation engine.
package nace_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int OPCODE_W = 2;
  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 12;
  localparam int BURN_W   = 12;
  localparam int RATIO_W  = 16;
  localparam int STATUS_W = 2;

  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int CNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W     = SAMPLE_BITS + ADDR_W;
  localparam int MEAN_W    = SAMPLE_BITS + 1;
  localparam int DEV_W     = SAMPLE_BITS + 2;
  localparam int PROD_W    = 2 * DEV_W;
  localparam int VAR_W     = 2 * SAMPLE_BITS + ADDR_W;
  localparam int COV_W     = VAR_W + 1;
  localparam int FRAC_BITS = 14;
  localparam int NUM_W     = VAR_W + FRAC_BITS;
  localparam int DEN_W     = VAR_W;
  localparam int STEP_W    = $clog2(NUM_W + 1);
  localparam int IDXSUM_W  = ((LAG_W > ADDR_W) ? LAG_W : ADDR_W) + 1;
  localparam int RATIO_ONE = 1 << FRAC_BITS;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = OPCODE_W'(0);
  localparam logic [OPCODE_W-1:0] OP_PUSH  = OPCODE_W'(1);
  localparam logic [OPCODE_W-1:0] OP_QUERY = OPCODE_W'(2);

  localparam logic [STATUS_W-1:0] STAT_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STAT_ZERO_VAR = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW = STATUS_W'(2);

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LAG_W-1:0]           lag;
  } in_item_t;

  typedef struct packed {
    logic [LAG_W-1:0]          lag_echo;
    logic signed [RATIO_W-1:0] ratio;
    logic [STATUS_W-1:0]       status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_PASS,
    ST_RATIO,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic push;
    logic query_start;
    logic mean_start;
    logic pass_start;
    logic ratio_start;
    logic load_out;
  } nace_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic pass_done;
  } nace_sts_t;

endpackage

// ===== rtl/core/nace_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by mean and ratio.
module nace_div import nace_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [NUM_W-1:0]  num_q, num_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_q});
    rem_sub = rem_sh - {1'b0, den_q};
    busy_d  = busy_q;
    step_d  = step_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // Shift in the next dividend bit; the quotient fills num from the bottom.
      rem_d  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_d  = {num_q[NUM_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = !busy_q;
  assign quot_o = num_q;

endmodule

// ===== rtl/core/nace_dp.sv =====
// Datapath: sample store, run counters, deviation pipeline, accumulators and result register.
module nace_dp import nace_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BURN_W-1:0] cfg_wdata_i,
  input  in_item_t          in_data_i,
  input  nace_cmd_t         cmd_i,
  output nace_sts_t         sts_o,
  output out_item_t         out_data_o
);

  // run state
  logic [BURN_W-1:0]      burn_q, burn_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [BURN_W-1:0]      disc_q, disc_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic                   ovf_q, ovf_d;

  logic [SAMPLE_BITS-1:0] store_q [STORE_DEPTH];
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic signed [SAMPLE_BITS-1:0] push_s;

  // query state
  logic [LAG_W-1:0]         lag_q;
  logic signed [MEAN_W-1:0] mean_q;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic                     issue_q, issue_d;
  logic [IDXSUM_W-1:0]      idx_sum;
  logic                     pair_ok;
  logic [ADDR_W-1:0]        addr_a, addr_b;

  logic                     v1_q, v2_q, v3_q;
  logic                     pair1_q, pair2_q, pair3_q;
  logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic signed [DEV_W-1:0]  dev_a_q, dev_b_q;
  logic [PROD_W-1:0]        sq_q;
  logic signed [PROD_W-1:0] pr_q;
  logic [VAR_W-1:0]         var_q;
  logic signed [COV_W-1:0]  cov_q;

  // divider interface
  logic [SUM_W-1:0]  sum_abs;
  logic [NUM_W-1:0]  mean_num;
  logic [DEN_W-1:0]  mean_den;
  logic [COV_W-1:0]  cov_abs;
  logic [NUM_W-1:0]  ratio_num;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;
  logic signed [MEAN_W-1:0] mean_mag;
  logic [RATIO_W-1:0] ratio_mag;
  out_item_t         out_q;

  function automatic out_item_t out_data_d();
    out_item_t r;
    r.lag_echo = lag_q;
    if (var_q == '0) begin
      r.ratio  = '0;
      r.status = STAT_ZERO_VAR;
    end else begin
      r.ratio  = cov_q[COV_W-1] ? -ratio_mag : ratio_mag;
      r.status = ovf_q ? STAT_OVERFLOW : STAT_OK;
    end
    return r;
  endfunction

  assign push_s = in_data_i.sample[SAMPLE_BITS-1:0];

  always_comb begin
    burn_d  = burn_q;
    cnt_d   = cnt_q;
    disc_d  = disc_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    wr_en   = 1'b0;
    wr_addr = cnt_q[ADDR_W-1:0];
    if (cfg_we_i) begin
      burn_d = cfg_wdata_i;
    end
    if (cmd_i.clear) begin
      cnt_d  = '0;
      disc_d = '0;
      sum_d  = '0;
      ovf_d  = 1'b0;
    end else if (cmd_i.push) begin
      if (disc_q < burn_q) begin
        disc_d = disc_q + BURN_W'(1);
      end else if (cnt_q < CNT_W'(STORE_DEPTH)) begin
        wr_en = 1'b1;
        sum_d = sum_q + SUM_W'(push_s);
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burn_q <= '0;
      cnt_q  <= '0;
      disc_q <= '0;
      sum_q  <= '0;
      ovf_q  <= 1'b0;
    end else begin
      burn_q <= burn_d;
      cnt_q  <= cnt_d;
      disc_q <= disc_d;
      sum_q  <= sum_d;
      ovf_q  <= ovf_d;
    end
  end

  // pass address generation: index i and partner i + lag
  always_comb begin
    idx_sum = IDXSUM_W'(idx_q) + IDXSUM_W'(lag_q);
    pair_ok = (idx_sum < IDXSUM_W'(cnt_q));
    addr_a  = idx_q;
    addr_b  = idx_sum[ADDR_W-1:0];
    idx_d   = idx_q;
    issue_d = issue_q;
    if (cmd_i.pass_start) begin
      idx_d   = '0;
      issue_d = 1'b1;
    end else if (issue_q) begin
      idx_d = idx_q + ADDR_W'(1);
      if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
        issue_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= push_s;
    end
    rd_a_q <= store_q[addr_a];
    rd_b_q <= store_q[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      idx_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      issue_q <= issue_d;
      idx_q   <= idx_d;
      v1_q    <= issue_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pair1_q <= pair_ok;
    pair2_q <= pair1_q;
    pair3_q <= pair2_q;
    dev_a_q <= DEV_W'(rd_a_q) - DEV_W'(mean_q);
    dev_b_q <= DEV_W'(rd_b_q) - DEV_W'(mean_q);
    sq_q    <= dev_a_q * dev_a_q;
    pr_q    <= dev_a_q * dev_b_q;
    if (cmd_i.query_start) begin
      lag_q <= in_data_i.lag;
      var_q <= '0;
      cov_q <= '0;
    end else if (v3_q) begin
      var_q <= var_q + VAR_W'(sq_q);
      if (pair3_q) begin
        cov_q <= cov_q + COV_W'(pr_q);
      end
    end
    if (cmd_i.pass_start) begin
      mean_q <= sum_q[SUM_W-1] ? -mean_mag : mean_mag;
    end
    if (cmd_i.load_out) begin
      out_q <= out_data_d();
    end
  end

  // mean = (2|sum| + n) / 2n, sign restored afterwards
  always_comb begin
    sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    mean_num  = NUM_W'({sum_abs, 1'b0}) + NUM_W'(cnt_q);
    mean_den  = DEN_W'({cnt_q, 1'b0});
    mean_mag  = div_quot[MEAN_W-1:0];
    cov_abs   = cov_q[COV_W-1] ? COV_W'(-cov_q) : COV_W'(cov_q);
    ratio_num = {cov_abs[VAR_W-1:0], {FRAC_BITS{1'b0}}};
    ratio_mag = (div_quot > NUM_W'(RATIO_ONE)) ? RATIO_W'(RATIO_ONE)
                                               : div_quot[RATIO_W-1:0];
  end

  nace_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mean_start | cmd_i.ratio_start),
    .num_i   (cmd_i.ratio_start ? ratio_num : mean_num),
    .den_i   (cmd_i.ratio_start ? var_q : mean_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.div_done  = div_done;
  assign sts_o.pass_done = !issue_q && !v1_q && !v2_q && !v3_q;
  assign out_data_o      = out_q;

endmodule

// ===== rtl/core/nace_ctrl.sv =====
// Controller: opcode dispatch, query sequencing and output valid.
module nace_ctrl import nace_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic                out_stall_i,
  input  nace_sts_t           sts_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output nace_cmd_t           cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (opcode_i)
            OP_CLEAR: cmd_o.clear = 1'b1;
            OP_PUSH:  cmd_o.push  = 1'b1;
            OP_QUERY: begin
              cmd_o.query_start = 1'b1;
              // empty run: variance is zero, skip straight to the result
              if (sts_i.empty) begin
                state_d = ST_FINISH;
              end else begin
                cmd_o.mean_start = 1'b1;
                state_d          = ST_MEAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MEAN: begin
        if (sts_i.div_done) begin
          cmd_o.pass_start = 1'b1;
          state_d          = ST_PASS;
        end
      end
      ST_PASS: begin
        if (sts_i.pass_done) begin
          cmd_o.ratio_start = 1'b1;
          state_d           = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (sts_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/normalized_autocorrelation_engine_top.sv =====
// Top level of the normalized autocorrelation engine.
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_we_i                cfg_wdata_i (burn_in)
//   in        in         in_valid_i/in_stall_o   in_data_i (opcode, sample, lag)
//   out       out        out_valid_o/out_stall_i out_data_o (lag_echo, ratio, status)
//
// Pushes stream one beat per cycle while no query runs; clear and push keep ST_IDLE.
// A query over n stored samples runs the serial divider (NUM_W = 58 dividend bits)
// once for the mean and once for the ratio, and walks the store once through its
// two read ports. An empty run skips the divider and the pass.
// Input is stalled while a query runs; the output register frees the input side.
// Reset is asynchronous, active low; the store itself is not cleared.
module normalized_autocorrelation_engine_top import nace_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BURN_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  nace_cmd_t cmd;
  nace_sts_t sts;

  nace_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  nace_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/autocorr_checker.sv =====
// Checker that predicts the engine's lag answers from the observed beats and compares them.
`timescale 1ns / 1ps
module autocorr_checker import nace_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BURN_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_data_i,
  output int                mismatch_count_o,
  output int                pending_o
);

  int                run_samples [STORE_DEPTH];
  int                kept_count    = 0;
  int                dropped_count = 0;
  longint            sample_sum    = 0;
  bit                overrun       = 1'b0;
  logic [BURN_W-1:0] burn_len      = '0;
  out_item_t         pending_answers [$];
  out_item_t         answer;
  out_item_t         wanted;
  int                errors        = 0;

  // Update the run state for one beat; return 1 when the beat yields an answer.
  function automatic bit predict_answer(input in_item_t beat, output out_item_t result);
    longint mean;
    longint mag;
    longint da;
    longint db;
    longint sq_sum;
    longint cross_sum;
    longint quo;
    bit     answered;
    result    = '0;
    answered  = 1'b0;
    mean      = 0;
    sq_sum    = 0;
    cross_sum = 0;
    case (beat.opcode)
      OP_CLEAR: begin
        kept_count    = 0;
        dropped_count = 0;
        sample_sum    = 0;
        overrun       = 1'b0;
      end
      OP_PUSH: begin
        if (dropped_count < burn_len) begin
          dropped_count++;
        end else if (kept_count < STORE_DEPTH) begin
          run_samples[kept_count] = $signed(beat.sample);
          sample_sum += $signed(beat.sample);
          kept_count++;
        end else begin
          overrun = 1'b1;
        end
      end
      OP_QUERY: begin
        if (kept_count > 0) begin
          // round half away from zero
          mag  = (sample_sum < 0) ? -sample_sum : sample_sum;
          mean = (2 * mag + kept_count) / (2 * kept_count);
          if (sample_sum < 0) mean = -mean;
          for (int i = 0; i < kept_count; i++) begin
            da = run_samples[i] - mean;
            sq_sum += da * da;
          end
          for (int i = 0; i + beat.lag < kept_count; i++) begin
            da = run_samples[i] - mean;
            db = run_samples[i + beat.lag] - mean;
            cross_sum += da * db;
          end
        end
        result.lag_echo = beat.lag;
        if (sq_sum == 0) begin
          result.ratio  = '0;
          result.status = STAT_ZERO_VAR;
        end else begin
          quo = (cross_sum * RATIO_ONE) / sq_sum;
          if (quo > RATIO_ONE) quo = RATIO_ONE;
          if (quo < -RATIO_ONE) quo = -RATIO_ONE;
          result.ratio  = RATIO_W'(quo);
          result.status = overrun ? STAT_OVERFLOW : STAT_OK;
        end
        answered = 1'b1;
      end
      default: ;
    endcase
    return answered;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_count    = 0;
      dropped_count = 0;
      sample_sum    = 0;
      overrun       = 1'b0;
      burn_len      = '0;
      pending_answers.delete();
      pending_o        <= 0;
      mismatch_count_o <= errors;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (predict_answer(in_data_i, answer)) pending_answers.push_back(answer);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got lag_echo=%0d ratio=%0d status=%0d",
                   $time, out_data_i.lag_echo, out_data_i.ratio, out_data_i.status);
        end else begin
          wanted = pending_answers.pop_front();
          if (out_data_i.lag_echo !== wanted.lag_echo || out_data_i.ratio !== wanted.ratio ||
              out_data_i.status !== wanted.status) begin
            errors++;
            $display("%0t: mismatch: expected lag_echo=%0d ratio=%0d status=%0d, got %0d %0d %0d",
                     $time, wanted.lag_echo, wanted.ratio, wanted.status,
                     out_data_i.lag_echo, out_data_i.ratio, out_data_i.status);
          end
        end
      end
      if (cfg_we_i) burn_len = cfg_wdata_i;
      mismatch_count_o <= errors;
      pending_o        <= pending_answers.size();
    end
  end

endmodule

// ===== tb/tb_normalized_autocorrelation_engine_top.sv =====
// Testbench top: drives beats and burn-in settings into the engine and reports the verdict.
`timescale 1ns / 1ps
module tb_normalized_autocorrelation_engine_top;
  import nace_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 300;
  localparam int SHORT_PUSHES   = 40;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = OPCODE_W'(3);

  typedef enum int {SHAPE_FULL, SHAPE_NARROW, SHAPE_FLAT, SHAPE_RAIL} shape_e;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [BURN_W-1:0] cfg_wdata  = '0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  in_item_t          in_data    = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  out_item_t         out_data;
  int                mismatches;
  int                answers_due;
  int                idle_in_pct  = 0;
  int                stall_pct    = 0;
  logic              hold_tgl     = 1'b0;
  logic              hold_seen    = 1'b0;
  int                hold_left    = 0;
  int                quiet_cycles = 0;

  normalized_autocorrelation_engine_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  autocorr_checker answer_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (answers_due)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off each time hold_tgl flips.
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("normalized_autocorrelation_engine_top test failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                           input logic [LAG_W-1:0] lg);
    in_item_t beat;
    beat.opcode = op;
    beat.sample = smp;
    beat.lag    = lg;
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Stop offering beats and wait until every pending answer is back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (answers_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic start_phase(input logic [BURN_W-1:0] burn, input int idle_pct,
                             input int stall_lvl);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= burn;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    idle_in_pct  = idle_pct;
    stall_pct   <= stall_lvl;
  endtask

  function automatic logic [LAG_W-1:0] pick_lag(input int len);
    if ($urandom_range(99) < 80) return LAG_W'($urandom_range(len + 1));
    return LAG_W'($urandom);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input shape_e shape,
                                                      input logic [SAMPLE_W-1:0] base);
    case (shape)
      SHAPE_FULL:   return SAMPLE_W'($urandom);
      SHAPE_NARROW: return SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
      SHAPE_FLAT:   return base;
      default:      return $urandom_range(1) ? 16'h7fff : 16'h8000;
    endcase
  endfunction

  // Mostly well-formed runs (clear, pushes, queries) with some raw noise beats.
  task automatic random_runs(input int budget, input bit open_with_clear);
    int                  sent;
    int                  len;
    int                  k;
    bit                  first;
    shape_e              shape;
    logic [SAMPLE_W-1:0] base;
    logic [OPCODE_W-1:0] op;
    sent  = 0;
    first = 1'b1;
    while (sent < budget) begin
      if ($urandom_range(99) < 15) begin
        op = OPCODE_W'($urandom);
        send_beat(op, SAMPLE_W'($urandom), LAG_W'($urandom));
        if (op != OP_UNUSED) sent++;
      end else begin
        if (open_with_clear || !first) begin
          send_beat(OP_CLEAR, SAMPLE_W'($urandom), LAG_W'($urandom));
          sent++;
        end
        len   = ($urandom_range(99) < 85) ? $urandom_range(24) : $urandom_range(200, 25);
        shape = shape_e'($urandom_range(3));
        base  = SAMPLE_W'($urandom);
        for (k = 0; k < len; k++) begin
          send_beat(OP_PUSH, draw_sample(shape, base), LAG_W'($urandom));
          sent++;
          if ($urandom_range(5) == 0) begin
            send_beat(OP_QUERY, SAMPLE_W'($urandom), pick_lag(k + 1));
            sent++;
          end
        end
        repeat ($urandom_range(3, 1)) begin
          send_beat(OP_QUERY, SAMPLE_W'($urandom), pick_lag(len));
          sent++;
        end
      end
      first = 1'b0;
    end
  endtask

  task automatic fill_store(input int pushes, input int queries);
    send_beat(OP_CLEAR, '0, '0);
    repeat (pushes) send_beat(OP_PUSH, SAMPLE_W'($urandom), LAG_W'($urandom));
    send_beat(OP_QUERY, '0, '0);
    send_beat(OP_QUERY, '0, 12'hfff);
    repeat (queries) send_beat(OP_QUERY, SAMPLE_W'($urandom), LAG_W'($urandom_range(8)));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    start_phase(12'd0, 0, 0);
    send_beat(OP_QUERY, '0, '0);            // empty run
    send_beat(OP_UNUSED, 16'h1234, 12'h0ff);
    send_beat(OP_PUSH, 16'h7fff, '0);
    send_beat(OP_PUSH, 16'h8000, 12'hfff);
    send_beat(OP_QUERY, '0, 12'd0);
    send_beat(OP_QUERY, 16'hffff, 12'd1);
    send_beat(OP_QUERY, '0, 12'hfff);       // lag past the run
    send_beat(OP_CLEAR, 16'hffff, 12'hfff);
    repeat (3) send_beat(OP_PUSH, 16'd5, '0);
    send_beat(OP_QUERY, '0, 12'd1);         // flat run
    // mean -0.5 must round to -1
    send_beat(OP_CLEAR, '0, '0);
    repeat (3) send_beat(OP_PUSH, 16'd0, '0);
    send_beat(OP_PUSH, 16'hfffe, '0);
    send_beat(OP_QUERY, '0, 12'd1);
    // mean 0.5 must round to 1
    send_beat(OP_CLEAR, '0, '0);
    repeat (3) send_beat(OP_PUSH, 16'd0, '0);
    send_beat(OP_PUSH, 16'd2, '0);
    send_beat(OP_QUERY, '0, 12'd1);

    start_phase(12'd2, 63, 0);
    random_runs(150, 1'b1);

    start_phase(12'd7, 0, 63);
    hold_tgl <= ~hold_tgl;
    random_runs(150, 1'b1);

    // keep the open run across the burn-in change
    start_phase(12'd0, 6, 6);
    random_runs(150, 1'b0);

    // every push lands in burn-in, so the run stays empty
    start_phase(12'hfff, 0, 0);
    fill_store(SHORT_PUSHES, 1);

    start_phase(12'd0, 0, 0);
    fill_store(SHORT_PUSHES, 1);

    start_phase(12'd1, 0, 0);
    random_runs(150, 1'b1);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("normalized_autocorrelation_engine_top test passed");
    else $display("normalized_autocorrelation_engine_top test failed");
    $finish;
  end

endmodule
